>>> src/field_edge_column_run_tracker_unit_defines.svh
// Assertion macros shared by the field edge column run tracker RTL.
`ifndef FIELD_EDGE_COLUMN_RUN_TRACKER_UNIT_DEFINES_SVH
`define FIELD_EDGE_COLUMN_RUN_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when cond holds, prop holds on that edge.
`define FECRT_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when cond holds, prop holds on the following edge.
`define FECRT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: next-cycle implication");

`else

`define FECRT_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define FECRT_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

>>> src/fecrt_pkg.sv
// Package: types, constants and helpers of the field edge column run tracker.
`default_nettype none

package fecrt_pkg;

   // Storage dimensions
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // Field widths
   localparam int LABEL_W = 8;
   localparam int COL_W   = 10;
   localparam int ROW_W   = 10;
   localparam int RUN_W   = 11;
   localparam int CFG_W   = 11;
   localparam int IDX_W   = $clog2(MAX_WIDTH);
   localparam int SWP_W   = IDX_W + 1;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Saturation limits
   localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
   localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};

   // Register reset values
   localparam logic [LABEL_W-1:0] FIELD_LABEL_RST = 8'd0;
   localparam logic [CFG_W-1:0]   MIN_RUN_RST     = 11'd5;
   localparam logic [CFG_W-1:0]   IMG_WIDTH_RST   = 11'd640;
   localparam logic [CFG_W-1:0]   IMG_HEIGHT_RST  = 11'd480;

   // Register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_FIELD_LABEL = 2'd0,
      REG_MIN_RUN     = 2'd1,
      REG_IMG_WIDTH   = 2'd2,
      REG_IMG_HEIGHT  = 2'd3
   } reg_index_type;

   // Input command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FRAME = 1'b1;

   // One column's stored state
   typedef struct packed {
      logic [RUN_W-1:0] run;
      logic [ROW_W-1:0] edge_row;
   } col_entry_type;

   // Columns in use: image width limited to storage depth
   function automatic logic [SWP_W-1:0] active_width(input logic [CFG_W-1:0] w);
      logic [SWP_W-1:0] lim;
      lim = SWP_W'(MAX_WIDTH);
      if ({1'b0, w} > {{(SWP_W+1-CFG_W){1'b0}}, lim}) begin
         return lim;
      end
      return SWP_W'(w);
   endfunction

   // Edge row loaded at frame start: height minus one, clamped
   function automatic logic [ROW_W-1:0] edge_reset_value(input logic [CFG_W-1:0] h);
      logic [CFG_W:0] hc;
      hc = {1'b0, h};
      if (hc > (CFG_W+1)'(MAX_HEIGHT)) begin
         hc = (CFG_W+1)'(MAX_HEIGHT);
      end
      if (hc == '0) begin
         return '0;
      end
      hc = hc - 1'b1;
      if (hc > {{(CFG_W+1-ROW_W){1'b0}}, ROW_MAX}) begin
         return ROW_MAX;
      end
      return hc[ROW_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/fecrt_column_update.sv
// Per-pixel column update: run count advance, saturation and edge row capture.
`default_nettype none

module fecrt_column_update (
   input  fecrt_pkg::col_entry_type              cur_entry,
   input  logic [fecrt_pkg::LABEL_W-1:0]          label,
   input  logic [fecrt_pkg::ROW_W-1:0]            row,
   input  logic [fecrt_pkg::LABEL_W-1:0]          field_label,
   input  logic [fecrt_pkg::CFG_W-1:0]            min_run,
   output fecrt_pkg::col_entry_type              new_entry
);
   import fecrt_pkg::*;

   logic [RUN_W-1:0] run_inc;

   // Saturating increment of the run
   assign run_inc = (cur_entry.run == RUN_MAX) ? cur_entry.run : cur_entry.run + 1'b1;

   // Field pixel extends the run, others break it
   always_comb begin
      new_entry = cur_entry;
      if (label == field_label) begin
         new_entry.run = run_inc;
         if (run_inc >= RUN_W'(min_run)) begin
            new_entry.edge_row = row;
         end
      end else begin
         new_entry.run = '0;
      end
   end

endmodule

`default_nettype wire

>>> src/field_edge_column_run_tracker_unit.sv
// Top level of the field edge column run tracker: handshake, column memory, CSRs.
//
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+-----------------
//   req     | in        | req_cmd, req_label, req_column, req_row | req_valid/ready
//   rsp     | out       | rsp_out_column, rsp_edge_row            | rsp_valid/ready
//   csr     | in/out    | csr_psel .. csr_prdata, csr_pready      | APB write/read
//
// One pixel transaction enters every cycle while the update stage can advance:
// the column memory read is registered, the update and write-back follow in the
// update stage, with the last write forwarded on a same-column back-to-back hit.
// Reset starts a clearing pass over all 1024 column memory entries; a frame start
// command runs a pass over the active-width columns. No transaction is accepted
// during a pass. A stalled result holds the update stage, which then holds req.
`default_nettype none

`include "field_edge_column_run_tracker_unit_defines.svh"

module field_edge_column_run_tracker_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Pixel / command transactions
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [fecrt_pkg::LABEL_W-1:0]       req_label,
   input  logic [fecrt_pkg::COL_W-1:0]         req_column,
   input  logic [fecrt_pkg::ROW_W-1:0]         req_row,
   // Edge row results
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fecrt_pkg::COL_W-1:0]         rsp_out_column,
   output logic [fecrt_pkg::ROW_W-1:0]         rsp_edge_row,
   // Configuration registers
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fecrt_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fecrt_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [fecrt_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import fecrt_pkg::*;

   // Configuration registers
   logic [LABEL_W-1:0] field_label_ff;
   logic [CFG_W-1:0]   min_run_ff;
   logic [CFG_W-1:0]   img_width_ff;
   logic [CFG_W-1:0]   img_height_ff;
   reg_index_type      csr_idx;
   logic               csr_wr;

   // Clearing pass
   logic               sweep_active_ff;
   logic [SWP_W-1:0]   sweep_idx_ff;
   logic [SWP_W-1:0]   sweep_limit_ff;
   logic [ROW_W-1:0]   sweep_edge_ff;
   logic [SWP_W-1:0]   sweep_idx_in;
   logic               sweep_last;

   // Column memory
   col_entry_type      col_mem [MAX_WIDTH];
   col_entry_type      rd_data_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   col_entry_type      mem_wdata;

   // Update stage
   logic               s1_valid_ff;
   logic               s1_keep_ff;
   logic [LABEL_W-1:0] s1_label_ff;
   logic [COL_W-1:0]   s1_column_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   col_entry_type      s1_entry;
   col_entry_type      s1_new_entry;
   logic               s1_adv;

   // Last write, forwarded on a same-column hit
   logic               lw_valid_ff;
   logic [COL_W-1:0]   lw_column_ff;
   col_entry_type      lw_entry_ff;

   // Result register
   logic               rsp_valid_ff;
   logic [COL_W-1:0]   rsp_column_ff;
   logic [ROW_W-1:0]   rsp_edge_ff;

   logic               req_acc;
   logic               pix_acc;
   logic               frame_acc;
   logic [SWP_W-1:0]   act_width;

   assign act_width = active_width(img_width_ff);

   // Handshake decode
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !sweep_active_ff && (!s1_valid_ff || s1_adv);
   assign req_acc   = req_valid && req_ready;
   assign pix_acc   = req_acc && (req_cmd == CMD_PIXEL);
   assign frame_acc = req_acc && (req_cmd == CMD_FRAME);

   // CSR write/read decode
   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_idx)
         REG_FIELD_LABEL: csr_prdata = CSR_DATA_W'(field_label_ff);
         REG_MIN_RUN:     csr_prdata = CSR_DATA_W'(min_run_ff);
         REG_IMG_WIDTH:   csr_prdata = CSR_DATA_W'(img_width_ff);
         REG_IMG_HEIGHT:  csr_prdata = CSR_DATA_W'(img_height_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_label_ff <= FIELD_LABEL_RST;
         min_run_ff     <= MIN_RUN_RST;
         img_width_ff   <= IMG_WIDTH_RST;
         img_height_ff  <= IMG_HEIGHT_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_FIELD_LABEL: field_label_ff <= csr_pwdata[LABEL_W-1:0];
            REG_MIN_RUN:     min_run_ff     <= csr_pwdata[CFG_W-1:0];
            REG_IMG_WIDTH:   img_width_ff   <= csr_pwdata[CFG_W-1:0];
            REG_IMG_HEIGHT:  img_height_ff  <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Clearing pass sequencing
   assign sweep_idx_in = sweep_idx_ff + 1'b1;
   assign sweep_last   = (sweep_idx_in == sweep_limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_active_ff <= 1'b1;
         sweep_idx_ff    <= '0;
         sweep_limit_ff  <= SWP_W'(MAX_WIDTH);
         sweep_edge_ff   <= edge_reset_value(IMG_HEIGHT_RST);
      end else if (sweep_active_ff) begin
         sweep_idx_ff <= sweep_idx_in;
         if (sweep_last) begin
            sweep_active_ff <= 1'b0;
         end
      end else if (frame_acc) begin
         sweep_active_ff <= (act_width != '0);
         sweep_idx_ff    <= '0;
         sweep_limit_ff  <= act_width;
         sweep_edge_ff   <= edge_reset_value(img_height_ff);
      end
   end

   // Forward the last write over the memory read
   assign s1_entry = (lw_valid_ff && (lw_column_ff == s1_column_ff)) ? lw_entry_ff : rd_data_ff;

   fecrt_column_update u_update (
      .cur_entry   (s1_entry),
      .label       (s1_label_ff),
      .row         (s1_row_ff),
      .field_label (field_label_ff),
      .min_run     (min_run_ff),
      .new_entry   (s1_new_entry)
   );

   // Memory write port: clearing pass or write-back
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = s1_column_ff;
      mem_wdata = s1_new_entry;
      if (sweep_active_ff) begin
         mem_we             = 1'b1;
         mem_waddr          = sweep_idx_ff[IDX_W-1:0];
         mem_wdata.run      = '0;
         mem_wdata.edge_row = sweep_edge_ff;
      end else if (s1_adv && s1_keep_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         col_mem[mem_waddr] <= mem_wdata;
      end
      if (pix_acc) begin
         rd_data_ff <= col_mem[req_column];
      end
   end

   // Update stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         if (pix_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (sweep_active_ff) begin
            lw_valid_ff <= 1'b0;
         end else if (s1_adv && s1_keep_ff) begin
            lw_valid_ff <= 1'b1;
         end
      end
   end

   // Update stage and last-write payload
   always_ff @(posedge clock) begin
      if (pix_acc) begin
         s1_keep_ff   <= ({1'b0, req_column} < act_width);
         s1_label_ff  <= req_label;
         s1_column_ff <= req_column;
         s1_row_ff    <= req_row;
      end
      if (s1_adv && s1_keep_ff) begin
         lw_column_ff <= s1_column_ff;
         lw_entry_ff  <= s1_new_entry;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_keep_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_keep_ff) begin
         rsp_column_ff <= s1_column_ff;
         rsp_edge_ff   <= s1_new_entry.edge_row;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_column = rsp_column_ff;
   assign rsp_edge_row   = rsp_edge_ff;

   // Checks
   `FECRT_ASSERT_IMPLIES(a_no_accept_in_sweep, clock, reset, sweep_active_ff, !req_ready)
   `FECRT_ASSERT_IMPLIES(a_stage_empty_in_sweep, clock, reset, sweep_active_ff, !s1_valid_ff)
   `FECRT_ASSERT_NEXT(a_frame_starts_sweep, clock, reset, frame_acc && (act_width != '0), sweep_active_ff)
   `FECRT_ASSERT_NEXT(a_result_loaded, clock, reset, s1_adv && s1_keep_ff, rsp_valid_ff && (rsp_column_ff == $past(s1_column_ff)))

endmodule

`default_nettype wire
